/* rtl/msc_pkg.sv */
// ============================================================================
// msc_pkg : shared types for the markdown span colouriser
// Colour register set, result entry layout and status groups between modules.
// ============================================================================
package msc_pkg;

  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int POS_W      = 7;   // line position, holds the limit itself
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [COLOR_W-1:0] normal;
    logic [COLOR_W-1:0] bold;
    logic [COLOR_W-1:0] italic;
    logic [COLOR_W-1:0] mono;
    logic [COLOR_W-1:0] header_one;
    logic [COLOR_W-1:0] header_two;
  } colors_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  character;
    logic [COLOR_W-1:0] color;
    logic               end_of_line;
    logic               last_in_run;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } result_t;

  typedef struct packed {
    logic             held_valid;
    logic [POS_W-1:0] line_pos;
  } trk_status_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
  } fifo_status_t;

endpackage

/* rtl/msc_span_tracker.sv */
// ============================================================================
// msc_span_tracker : span state and per-character colour decision
// Holds one character back, colours it against its lookahead and gives up to
// two results per character (the held one, and the final one at line end).
// ============================================================================
module msc_span_tracker
  import msc_pkg::*;
#(
  parameter int MAX_LINE = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic [CHAR_W-1:0] item_char,
  input  logic              item_last,
  input  colors_t           colors,
  output result_t           res0,
  output result_t           res1,
  output trk_status_t       status
);

  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [POS_W-1:0]  LIMIT    = POS_W'(MAX_LINE);
  localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1);

  typedef enum logic [2:0] {
    M_NORMAL, M_BOLD, M_ITALIC, M_MONO, M_H1, M_H2
  } mode_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    mode_t              mode;
    logic               pend;
  } cls_t;

  function automatic cls_t classify(
    input logic [CHAR_W-1:0] c,
    input logic [CHAR_W-1:0] nx,
    input logic [CHAR_W-1:0] prev,
    input logic              at_start,
    input mode_t             mode,
    input logic              pend,
    input colors_t           col
  );
    cls_t r;
    logic may_head;
    may_head = at_start || (prev == CH_SPACE);
    r.mode   = mode;
    r.pend   = 1'b0;
    r.color  = col.normal;
    if (pend) begin
      r.color = col.bold;
    end else begin
      case (mode)
        M_BOLD: begin
          r.color = col.bold;
          if (c == CH_STAR && nx == CH_STAR) begin
            r.pend = 1'b1;
            r.mode = M_NORMAL;
          end
        end
        M_ITALIC: begin
          r.color = col.italic;
          if (c == CH_STAR) r.mode = M_NORMAL;
        end
        M_MONO: begin
          r.color = col.mono;
          if (c == CH_QUOTE) r.mode = M_NORMAL;
        end
        M_H1: r.color = col.header_one;
        M_H2: r.color = col.header_two;
        default: begin
          if (c == CH_STAR && nx == CH_STAR) begin
            r.mode  = M_BOLD;
            r.pend  = 1'b1;
            r.color = col.bold;
          end else if (c == CH_STAR) begin
            r.mode  = M_ITALIC;
            r.color = col.italic;
          end else if (c == CH_QUOTE) begin
            r.mode  = M_MONO;
            r.color = col.mono;
          end else if (c == CH_HASH && nx == CH_HASH && may_head) begin
            r.mode  = M_H2;
            r.color = col.header_two;
          end else if (c == CH_HASH && may_head) begin
            r.mode  = M_H1;
            r.color = col.header_one;
          end else begin
            r.mode  = M_NORMAL;
            r.color = col.normal;
          end
        end
      endcase
    end
    return r;
  endfunction

  mode_t             mode_r, mode_nxt;
  logic [CHAR_W-1:0] held_r, held_nxt;
  logic              held_v_r, held_v_nxt;
  logic [CHAR_W-1:0] prev_r, prev_nxt;
  logic              pend_r, pend_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // state after the held character has been handled
  mode_t             mode_a;
  logic [CHAR_W-1:0] held_a, prev_a;
  logic              held_v_a, pend_a, run1;
  logic [POS_W-1:0]  pos_a;
  cls_t              c1, c2;

  always_comb begin
    run1 = pos_r < LIMIT;
    c1   = classify(held_r, item_char, prev_r, pos_r == POS_ONE, mode_r, pend_r, colors);

    res0.valid            = item_valid && run1 && held_v_r;
    res0.data.character   = held_r;
    res0.data.color       = c1.color;
    res0.data.end_of_line = 1'b0;

    mode_a   = res0.valid ? c1.mode : mode_r;
    pend_a   = res0.valid ? c1.pend : pend_r;
    prev_a   = res0.valid ? held_r  : prev_r;
    held_a   = run1 ? item_char : held_r;
    held_v_a = run1 | held_v_r;
    pos_a    = run1 ? pos_r + POS_ONE : pos_r;

    // past the last character the lookahead is end of line
    c2 = classify(held_a, CH_NONE, prev_a, pos_a == POS_ONE, mode_a, pend_a, colors);

    res1.valid            = item_valid && item_last && held_v_a;
    res1.data.character   = held_a;
    res1.data.color       = c2.color;
    res1.data.end_of_line = 1'b1;
    res1.data.last_in_run = 1'b1;
    res0.data.last_in_run = !res1.valid;

    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    prev_nxt   = prev_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    pos_nxt    = pos_r;
    if (item_valid) begin
      if (item_last) begin
        mode_nxt   = M_NORMAL;
        pend_nxt   = 1'b0;
        prev_nxt   = CH_NONE;
        held_nxt   = CH_NONE;
        held_v_nxt = 1'b0;
        pos_nxt    = '0;
      end else begin
        mode_nxt   = mode_a;
        pend_nxt   = pend_a;
        prev_nxt   = prev_a;
        held_nxt   = held_a;
        held_v_nxt = held_v_a;
        pos_nxt    = pos_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      pend_r   <= 1'b0;
      prev_r   <= CH_NONE;
      held_r   <= CH_NONE;
      held_v_r <= 1'b0;
      pos_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pend_r   <= pend_nxt;
      prev_r   <= prev_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      pos_r    <= pos_nxt;
    end
  end

  assign status.held_valid = held_v_r;
  assign status.line_pos   = pos_r;

endmodule

/* rtl/msc_out_fifo.sv */
// ============================================================================
// msc_out_fifo : result queue
// Four-entry queue taking up to two results per cycle, one out per cycle.
// ============================================================================
module msc_out_fifo
  import msc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  result_t      push0,
  input  result_t      push1,
  input  logic         pop,
  output entry_t       head,
  output fifo_status_t status
);

  entry_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [FIFO_AW-1:0]   slot1;
  logic [FIFO_CW-1:0]   n_push;

  always_comb begin
    slot1      = push0.valid ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    n_push     = FIFO_CW'(push0.valid) + FIFO_CW'(push1.valid);
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + n_push - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0.valid) mem[wr_ptr_r] <= push0.data;
    if (push1.valid) mem[slot1]    <= push1.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head         = mem[rd_ptr_r];
  assign status.count = count_r;

endmodule

/* rtl/markdown_span_colorizer.sv */
// ============================================================================
// markdown_span_colorizer : per-character display colour for a markdown line
// Streams characters in, colours each one by bold/italic/mono/header spans,
// streams coloured characters out one character behind.
// ============================================================================
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------------
//  in_     | slave     | tvalid / tready    | tdata: character; tlast: line_end
//  out_    | master    | tvalid / tready    | tdata: out_character, color;
//          |           |                    | tlast: end_of_line; tuser: last_in_run
//  cfg_    | APB slave | psel/penable/pready| six 4-bit colour registers at 4*i
//
//  Flow: one character per cycle sustained while the result queue has room. A
//  character goes into the input register, is coloured from there and lands
//  in the result queue, which drives out_. A line-end character can give two
//  results, which the out_ side drains one a cycle; the four-entry result queue
//  sets how far the out_ side may lag.
//  Reset: synchronous, active low; clears span state and loads default colours.
//  Stalls: in_tready drops only while the input register holds a character and
//  the result queue has fewer than two free entries.
// ============================================================================
module markdown_span_colorizer
  import msc_pkg::*;
#(
  parameter int MAX_LINE = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] character
  input  logic        in_tlast,    // line_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] out_character, [11:8] color, [15:12] zero
  output logic        out_tlast,   // end_of_line
  output logic        out_tuser,   // last_in_run
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // register indexes, at byte address 4*index
  localparam logic [2:0] REG_NORMAL     = 3'd0;
  localparam logic [2:0] REG_BOLD       = 3'd1;
  localparam logic [2:0] REG_ITALIC     = 3'd2;
  localparam logic [2:0] REG_MONO       = 3'd3;
  localparam logic [2:0] REG_HEADER_ONE = 3'd4;
  localparam logic [2:0] REG_HEADER_TWO = 3'd5;

  // --------------------------------------------------------------------------
  // Colour registers
  // --------------------------------------------------------------------------
  colors_t            colors_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic [COLOR_W-1:0] cfg_val;
  logic [COLOR_W-1:0] rd_val;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_val    = cfg_pwdata[COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colors_r.normal     <= 4'd0;
      colors_r.bold       <= 4'd6;
      colors_r.italic     <= 4'd2;
      colors_r.mono       <= 4'd5;
      colors_r.header_one <= 4'd8;
      colors_r.header_two <= 4'd4;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NORMAL:     colors_r.normal     <= cfg_val;
        REG_BOLD:       colors_r.bold       <= cfg_val;
        REG_ITALIC:     colors_r.italic     <= cfg_val;
        REG_MONO:       colors_r.mono       <= cfg_val;
        REG_HEADER_ONE: colors_r.header_one <= cfg_val;
        REG_HEADER_TWO: colors_r.header_two <= cfg_val;
        default: ;      // unmapped, write ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NORMAL:     rd_val = colors_r.normal;
      REG_BOLD:       rd_val = colors_r.bold;
      REG_ITALIC:     rd_val = colors_r.italic;
      REG_MONO:       rd_val = colors_r.mono;
      REG_HEADER_ONE: rd_val = colors_r.header_one;
      REG_HEADER_TWO: rd_val = colors_r.header_two;
      default:        rd_val = '0;
    endcase
  end

  assign cfg_prdata = {{(32-COLOR_W){1'b0}}, rd_val};

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;
  logic              room, consume, in_acc;
  fifo_status_t      fifo_st;
  trk_status_t       trk_st;

  // a line end may push two results, so keep two entries spare
  assign room      = fifo_st.count < FIFO_CW'(FIFO_DEPTH - 1);
  assign consume   = in_valid_r && room;
  assign in_tready = !in_valid_r || consume;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Colouring and result queue
  // --------------------------------------------------------------------------
  result_t res0, res1;
  entry_t  head;

  msc_span_tracker #(
    .MAX_LINE (MAX_LINE)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (consume),
    .item_char  (in_char_r),
    .item_last  (in_last_r),
    .colors     (colors_r),
    .res0       (res0),
    .res1       (res1),
    .status     (trk_st)
  );

  msc_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push0  (res0),
    .push1  (res1),
    .pop    (out_tvalid && out_tready),
    .head   (head),
    .status (fifo_st)
  );

  assign out_tvalid = fifo_st.count != '0;
  assign out_tdata  = {4'b0000, head.color, head.character};
  assign out_tlast  = head.end_of_line;
  assign out_tuser  = head.last_in_run;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_st.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_held_pos : assert property (@(posedge clk) disable iff (!rst_n)
    trk_st.held_valid == (trk_st.line_pos != '0))
    else $error("held character flag out of step with line position");

  a_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
    trk_st.line_pos <= POS_W'(MAX_LINE))
    else $error("line position past the limit");

  a_line_clear : assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |=> !trk_st.held_valid)
    else $error("line state not cleared after line end");

endmodule

/* tb/sv/markdown_span_colorizer_test.sv */
// ============================================================================
// markdown_span_colorizer_test : self-checking bench for the span colouriser
// Streams text lines into the block, predicts the colour of every character
// from a line-level span tracker kept in the bench, and checks each result
// transaction in order. Colour registers are rewritten between phases, both
// channels idle at random, and the output side is held off to fill the block.
// ============================================================================
module markdown_span_colorizer_test
  import msc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINE     = 80;
  localparam int TOTAL_ITEMS  = 950;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_SETTLE = 8;       // covers the input register and result queue plus margin
  localparam int MAX_REPORTS  = 40;

  localparam logic [7:0] ASTERISK = 8'h2A;
  localparam logic [7:0] HASH     = 8'h23;
  localparam logic [7:0] SPACE    = 8'h20;
  localparam logic [7:0] QUOTE    = 8'h27;
  localparam logic [7:0] NO_CHAR  = 8'h00;  // lookahead past the end of line

  typedef enum logic [2:0] {
    SPAN_NORMAL, SPAN_BOLD, SPAN_ITALIC, SPAN_MONO, SPAN_HEAD1, SPAN_HEAD2
  } span_e;

  typedef enum int {
    REG_NORMAL = 0, REG_BOLD, REG_ITALIC, REG_MONO, REG_HEAD1, REG_HEAD2
  } colour_reg_e;

  // --------------------------------------------------------------------------
  // DUT signals, inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;  // [7:0] character
  logic        in_tlast    = 1'b0;   // line_end
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;            // [7:0] out_character, [11:8] color, [15:12] zero
  logic        out_tlast;            // end_of_line
  logic        out_tuser;            // last_in_run
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = 5'd0;
  logic [31:0] cfg_pwdata  = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  markdown_span_colorizer #(.MAX_LINE(MAX_LINE)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state: colour registers as the block should hold them, the span
  // tracker for the current line, and the coloured characters still owed.
  // --------------------------------------------------------------------------
  colors_t     colours;
  span_e       span;
  logic [7:0]  held_char;
  bit          held_valid;
  logic [7:0]  prev_char;
  bit          second_star_due;
  int          line_pos;

  entry_t      owed_glyphs[$];
  int          items_sent;
  int          mismatches;
  int          cycle_count;
  bit          no_idle;     // steady stretch: neither side idles
  int          hold_req;    // long output hold-off, picked up by the receiver
  int          hold_left;

  function automatic void clear_line();
    span            = SPAN_NORMAL;
    held_char       = 8'h00;
    held_valid      = 1'b0;
    prev_char       = 8'h00;
    second_star_due = 1'b0;
    line_pos        = 0;
  endfunction

  // Colour of the held character given the one after it; moves the span state.
  function automatic logic [3:0] span_colour(logic [7:0] c, logic [7:0] nx, bit at_start);
    bit may_head;
    may_head = at_start || prev_char == SPACE;
    // second star of a bold pair is never looked at again
    if (second_star_due) begin
      second_star_due = 1'b0;
      return colours.bold;
    end
    case (span)
      SPAN_BOLD: begin
        if (c == ASTERISK && nx == ASTERISK) begin
          second_star_due = 1'b1;
          span            = SPAN_NORMAL;
        end
        return colours.bold;
      end
      SPAN_ITALIC: begin
        if (c == ASTERISK) span = SPAN_NORMAL;
        return colours.italic;
      end
      SPAN_MONO: begin
        if (c == QUOTE) span = SPAN_NORMAL;
        return colours.mono;
      end
      SPAN_HEAD1: return colours.header_one;
      SPAN_HEAD2: return colours.header_two;
      default: begin
        if (c == ASTERISK && nx == ASTERISK) begin
          span            = SPAN_BOLD;
          second_star_due = 1'b1;
          return colours.bold;
        end
        if (c == ASTERISK) begin
          span = SPAN_ITALIC;
          return colours.italic;
        end
        if (c == QUOTE) begin
          span = SPAN_MONO;
          return colours.mono;
        end
        if (c == HASH && nx == HASH && may_head) begin
          span = SPAN_HEAD2;
          return colours.header_two;
        end
        if (c == HASH && may_head) begin
          span = SPAN_HEAD1;
          return colours.header_one;
        end
        span = SPAN_NORMAL;
        return colours.normal;
      end
    endcase
  endfunction

  // One accepted character gives zero, one or two coloured characters.
  function automatic void predict_colours(logic [7:0] c, logic line_end);
    entry_t got[2];
    int     n;
    n = 0;
    if (line_pos < MAX_LINE) begin
      if (held_valid) begin
        got[n].character   = held_char;
        got[n].color       = span_colour(held_char, c, line_pos == 1);
        got[n].end_of_line = 1'b0;
        got[n].last_in_run = 1'b0;
        n++;
        prev_char = held_char;
      end
      held_char  = c;
      held_valid = 1'b1;
      line_pos++;
    end
    // overlong lines: the held character waits here for the line end
    if (line_end) begin
      if (held_valid) begin
        got[n].character   = held_char;
        got[n].color       = span_colour(held_char, NO_CHAR, line_pos == 1);
        got[n].end_of_line = 1'b1;
        got[n].last_in_run = 1'b0;
        n++;
      end
      clear_line();
    end
    if (n > 0) got[n-1].last_in_run = 1'b1;
    for (int k = 0; k < n; k++) owed_glyphs.push_back(got[k]);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check each accepted transaction, then pick next tready
  // --------------------------------------------------------------------------
  function automatic void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s expected %0h actual %0h", $time, what, exp_v, act_v);
  endfunction

  function automatic void check_glyph();
    entry_t want;
    if (owed_glyphs.size() == 0) begin
      report("unexpected result, character", 8'h00, out_tdata[7:0]);
      return;
    end
    want = owed_glyphs.pop_front();
    if (out_tdata[7:0] !== want.character) report("character", want.character, out_tdata[7:0]);
    if (out_tdata[11:8] !== want.color) report("colour", 8'(want.color), 8'(out_tdata[11:8]));
    if (out_tlast !== want.end_of_line) report("end_of_line", 8'(want.end_of_line), 8'(out_tlast));
    if (out_tuser !== want.last_in_run) report("last_in_run", 8'(want.last_in_run), 8'(out_tuser));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_glyph();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 38);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. tvalid stays high after a transaction so that back-to-back
  // characters go in without a bubble; only an idle gap or a drain lowers it.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic line_end);
    int gap;
    gap = 0;
    if (!no_idle) while ($urandom_range(0, 99) < 38) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= line_end;
    do @(posedge clk); while (!in_tready);
    predict_colours(c, line_end);
    items_sent++;
  endtask

  task automatic send_line(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
  endtask

  // Markup-heavy alphabet so that spans open and close often.
  function automatic logic [7:0] random_glyph();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return ASTERISK;
    if (r < 22) return HASH;
    if (r < 34) return SPACE;
    if (r < 42) return QUOTE;
    if (r < 85) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_random_line(input int len);
    for (int k = 0; k < len; k++) send_char(random_glyph(), k == len - 1);
  endtask

  // Sender pauses until every owed result is out, then lets the pipe settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (owed_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // APB transaction: setup cycle, access cycle, then back to idle.
  task automatic cfg_access(input colour_reg_e idx, input bit write,
                            input logic [3:0] value, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= 5'(4 * int'(idx));
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata        = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_colour(input colour_reg_e idx, input logic [3:0] value);
    logic [31:0] rd;
    cfg_access(idx, 1'b1, value, rd);
    case (idx)
      REG_NORMAL: colours.normal     = value;
      REG_BOLD:   colours.bold       = value;
      REG_ITALIC: colours.italic     = value;
      REG_MONO:   colours.mono       = value;
      REG_HEAD1:  colours.header_one = value;
      REG_HEAD2:  colours.header_two = value;
      default: ;
    endcase
    cfg_access(idx, 1'b0, 4'h0, rd);
    if (rd !== 32'(value)) begin
      mismatches++;
      $display("%0t ns: register %0d readback expected %0h actual %0h", $time, idx, value, rd);
    end
  endtask

  task automatic set_colours(input logic [3:0] n, b, i, m, h1, h2);
    drain();
    write_colour(REG_NORMAL, n);
    write_colour(REG_BOLD,   b);
    write_colour(REG_ITALIC, i);
    write_colour(REG_MONO,   m);
    write_colour(REG_HEAD1,  h1);
    write_colour(REG_HEAD2,  h2);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset colours; every span kind, headers, and the one-character lines
  // whose lookahead is the end of line.
  task automatic test_default_colours();
    send_line("**a**");   // bold pair opens and closes, last star at line end
    send_line("*i*");     // italic
    send_line("'q'");     // monospace
    send_line("##");      // level-2 header from line start
    send_line("a #");     // header after a space, lookahead is end of line
    send_line("a#");      // hash mid-word stays normal
    send_line("*");       // lone star at line end: italic
    send_line("#");       // lone hash: header one
    send_char(8'hFF, 1'b0);
    send_char(8'h01, 1'b1);
  endtask

  // Extremes and distinct settings of all six colour registers.
  task automatic test_colour_registers();
    set_colours(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
    repeat (4) send_random_line($urandom_range(1, 12));
    set_colours(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF);
    repeat (4) send_random_line($urandom_range(1, 12));
    set_colours(4'h1, 4'h3, 4'h7, 4'h9, 4'hC, 4'hE);
    send_line("# **b** *i* 'm'");
    send_line("## x");
  endtask

  // Lines around and past the length limit; the tail is dropped.
  task automatic test_overlong_lines();
    send_random_line(MAX_LINE - 1);
    send_random_line(MAX_LINE);
    send_random_line(MAX_LINE + 1);
    send_random_line(MAX_LINE + 12);
  endtask

  // Output held off while characters keep coming: the result queue fills and
  // the input must stall without losing anything.
  task automatic test_result_backpressure();
    drain();
    no_idle  = 1'b1;
    hold_req = 200;
    send_random_line(40);
    send_random_line(20);
    drain();
    no_idle = 1'b0;
  endtask

  // Mostly short markup lines, a few overlong, colours changed now and then,
  // and one stretch where neither side idles.
  task automatic test_random_lines();
    int next_recolour;
    next_recolour = items_sent + 200;
    while (items_sent < TOTAL_ITEMS) begin
      no_idle = (items_sent >= 600 && items_sent < 700);
      if (items_sent >= next_recolour) begin
        set_colours(4'($urandom), 4'($urandom), 4'($urandom),
                    4'($urandom), 4'($urandom), 4'($urandom));
        next_recolour = items_sent + 200;
      end
      if ($urandom_range(0, 24) == 0) send_random_line($urandom_range(70, 100));
      else send_random_line($urandom_range(1, 20));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    colours.normal     = 4'd0;
    colours.bold       = 4'd6;
    colours.italic     = 4'd2;
    colours.mono       = 4'd5;
    colours.header_one = 4'd8;
    colours.header_two = 4'd4;
    clear_line();
    items_sent  = 0;
    mismatches  = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
    hold_req    = 0;
    hold_left   = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_colours();
    test_colour_registers();
    test_overlong_lines();
    test_result_backpressure();
    test_random_lines();
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
